[rtl/gte_pkg.sv]
// Shared types and constants for the grille transposition encryptor.
// Holds default sizes, register codes, command and config structs, FSM states.
// No dependencies; every other file except gte_ram imports this package.
package gte_pkg;

    // Default grid and output sizes
    localparam int DEF_GRID_ROWS  = 3;
    localparam int DEF_GRID_COLS  = 10;
    localparam int DEF_MAX_OUTPUT = 4096;

    // Fixed field widths
    localparam int MASK_BITS    = 30;
    localparam int CHAR_W       = 8;
    localparam int INDEX_W      = 12;
    localparam int CFG_DATA_W   = 30;
    localparam int CFG_IDX_W    = 3;

    // At most this many words leave for one item
    localparam int RESULT_LIMIT = 32;
    localparam int RESULT_CNT_W = 6;

    // Cell count field of a readout command; covers the largest grid (8 x 16)
    localparam int CMD_CNT_W    = 8;

    // Register reset values
    localparam logic [MASK_BITS-1:0] MASK_RESET   = 30'd391818205;
    localparam logic [CHAR_W-1:0]    MARKER_RESET = 8'd43;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPEN_MASK    = 3'd0,
        CFG_EMPTY_MARKER = 3'd1,
        CFG_IND1_CHAR    = 3'd2,
        CFG_IND1_INDEX   = 3'd3,
        CFG_IND2_CHAR    = 3'd4,
        CFG_IND2_INDEX   = 3'd5
    } cfg_reg_t;

    // Readout settings seen by the back end
    typedef struct packed {
        logic [CHAR_W-1:0]  empty_marker;
        logic [CHAR_W-1:0]  ind1_char;
        logic [INDEX_W-1:0] ind1_index;
        logic [CHAR_W-1:0]  ind2_char;
        logic [INDEX_W-1:0] ind2_index;
    } cipher_cfg_t;

    // Readout request from front to back
    typedef struct packed {
        logic                 bank;
        logic [CMD_CNT_W-1:0] count;
        logic                 is_final;
    } readout_cmd_t;

    // Bank handed back to the front after readout
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_release_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_FILL,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ADDR,
        B_DATA,
        B_EMIT,
        B_FINISH
    } back_state_t;

endpackage

[rtl/gte_in_if.sv]
// Plaintext input channel: valid/ready handshake with one character per word.
// Depends on gte_pkg for the character width.
interface gte_in_if import gte_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] plain_char;
    logic              is_final;

    modport source (output valid, output plain_char, output is_final, input ready);
    modport sink   (input valid, input plain_char, input is_final, output ready);
endinterface

[rtl/gte_out_if.sv]
// Ciphertext output channel: valid/ready handshake with one character per word.
// Depends on gte_pkg for the character width.
interface gte_out_if import gte_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] cipher_char;
    logic              run_end;

    modport source (output valid, output cipher_char, output run_end, input ready);
    modport sink   (input valid, input cipher_char, input run_end, output ready);
endinterface

[rtl/gte_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module gte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port, registered read port; read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/gte_front.sv]
// Front end: accepts plaintext words and places them into the current grid bank.
// Fills closed cells with the marker, detects group end, queues readout commands.
// Depends on gte_pkg and gte_in_if.
module gte_front import gte_pkg::*; #(
    parameter int GRID_ROWS = DEF_GRID_ROWS,
    parameter int GRID_COLS = DEF_GRID_COLS,
    localparam int CELL_COUNT = GRID_ROWS * GRID_COLS,
    localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    gte_in_if.sink               plain_in,
    input  logic [MASK_BITS-1:0] open_cell_mask,
    input  logic [CHAR_W-1:0]    empty_marker,
    output logic                 ram_we,
    output logic [ADDR_W:0]      ram_waddr,
    output logic [CHAR_W-1:0]    ram_wdata,
    output logic                 cmd_valid,
    output readout_cmd_t         cmd,
    input  logic                 cmd_ready,
    input  bank_release_t        bank_free
);

    localparam int CNT_W = $clog2(CELL_COUNT + 1);

    // Cells that exist in the grid; mask bits past the last cell never count as open
    localparam logic [31:0] GRID_MASK =
        (CELL_COUNT >= 32) ? '1 : ((32'd1 << CELL_COUNT) - 32'd1);

    front_state_t      state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              final_reg, final_next;
    logic              bank_reg, bank_next;
    logic [1:0]        pending_reg, pending_next;

    logic              accept;
    logic              push;
    logic [31:0]       mask_w;
    logic [31:0]       mask_at_fill;
    logic [31:0]       mask_after_fill;
    logic [CNT_W-1:0]  fill_inc;
    logic              fill_room;
    logic              fill_open;
    logic              more_open;

    // Mask lookups; cells past the mask width read as closed
    assign mask_w          = 32'(open_cell_mask) & GRID_MASK;
    assign fill_inc        = fill_reg + CNT_W'(1);
    assign mask_at_fill    = mask_w >> fill_reg;
    assign mask_after_fill = mask_w >> fill_inc;
    assign fill_room       = fill_reg < CNT_W'(CELL_COUNT);
    assign fill_open       = mask_at_fill[0];
    assign more_open       = |mask_after_fill;

    assign accept = plain_in.valid && plain_in.ready;
    assign push   = cmd_valid && cmd_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_FILL;
                end
            end
            F_FILL:
            begin
                if (!fill_room)
                begin
                    state_next = F_PUSH;
                end
                else if (fill_open)
                begin
                    state_next = (!more_open || final_reg) ? F_PUSH : F_IDLE;
                end
            end
            F_PUSH:
            begin
                if (cmd_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        plain_in.ready = (state_reg == F_IDLE) && !pending_reg[bank_reg];
        ram_we         = (state_reg == F_FILL) && fill_room;
        ram_waddr      = {bank_reg, fill_reg[ADDR_W-1:0]};
        ram_wdata      = fill_open ? char_reg : empty_marker;
        cmd_valid      = (state_reg == F_PUSH);
        cmd.bank       = bank_reg;
        cmd.count      = CMD_CNT_W'(fill_reg);
        cmd.is_final   = final_reg;
    end

    // Datapath: latch word, advance fill, flip bank on push, track busy banks
    always_comb
    begin
        char_next    = char_reg;
        final_next   = final_reg;
        fill_next    = fill_reg;
        bank_next    = bank_reg;
        pending_next = pending_reg;
        if (accept)
        begin
            char_next  = plain_in.plain_char;
            final_next = plain_in.is_final;
        end
        if (ram_we)
        begin
            fill_next = fill_inc;
        end
        if (bank_free.valid)
        begin
            pending_next[bank_free.bank] = 1'b0;
        end
        if (push)
        begin
            fill_next              = '0;
            bank_next              = !bank_reg;
            pending_next[bank_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            fill_reg    <= '0;
            final_reg   <= 1'b0;
            bank_reg    <= 1'b0;
            pending_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            final_reg   <= final_next;
            bank_reg    <= bank_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

endmodule

[rtl/gte_cmd_fifo.sv]
// Two-entry queue of readout commands between front and back end.
// Depends on gte_pkg for readout_cmd_t.
module gte_cmd_fifo import gte_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    input  readout_cmd_t push_cmd,
    output logic         push_ready,
    output logic         pop_valid,
    output readout_cmd_t pop_cmd,
    input  logic         pop
);

    readout_cmd_t entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         do_push;
    logic         do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/gte_back.sv]
// Back end: reads a finished bank column by column, skips marker cells,
// inserts indicators and drives the output channel through a hold stage.
// Depends on gte_pkg and gte_out_if.
module gte_back import gte_pkg::*; #(
    parameter int GRID_ROWS  = DEF_GRID_ROWS,
    parameter int GRID_COLS  = DEF_GRID_COLS,
    parameter int MAX_OUTPUT = DEF_MAX_OUTPUT,
    localparam int CELL_COUNT = GRID_ROWS * GRID_COLS,
    localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  readout_cmd_t      cmd,
    output logic              cmd_pop,
    output logic              ram_re,
    output logic [ADDR_W:0]   ram_raddr,
    input  logic [CHAR_W-1:0] ram_rdata,
    input  cipher_cfg_t       cfg,
    gte_out_if.source         cipher_out,
    output bank_release_t     bank_free
);

    localparam int CNT_W   = $clog2(CELL_COUNT + 1);
    localparam int ROW_W   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int COL_W   = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int POS_W   = $clog2(MAX_OUTPUT);
    localparam int CMP_W   = (POS_W > INDEX_W) ? POS_W : INDEX_W;
    localparam int IND_MAX = 2;

    back_state_t       state_reg, state_next;
    readout_cmd_t      cur_reg, cur_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [1:0]        ind_cnt_reg, ind_cnt_next;
    logic [RESULT_CNT_W-1:0] res_cnt_reg, res_cnt_next;
    logic              held_valid_reg, held_valid_next;
    logic [CHAR_W-1:0] held_char_reg, held_char_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_end_reg, out_end_next;

    logic              last_row;
    logic              last_cell;
    logic              in_range;
    logic              is_marker;
    logic              ind1_hit;
    logic              ind2_hit;
    logic              ind_room;
    logic              ind_due;
    logic              limit_hit;
    logic              can_send;
    logic              can_put;
    logic              finish_go;

    // Control strobes from the output decode
    logic              adv;
    logic              put;
    logic [CHAR_W-1:0] put_char;
    logic              put_ind;
    logic              finish;

    // Cell walk and word classification
    assign last_row  = (row_reg == ROW_W'(GRID_ROWS - 1));
    assign last_cell = last_row && (col_reg == COL_W'(GRID_COLS - 1));
    assign in_range  = CMD_CNT_W'(idx_reg) < cur_reg.count;
    assign is_marker = (ram_rdata == cfg.empty_marker);
    assign ind1_hit  = (cfg.ind1_char != '0) && (CMP_W'(cfg.ind1_index) == CMP_W'(pos_reg));
    assign ind2_hit  = (cfg.ind2_char != '0) && (CMP_W'(cfg.ind2_index) == CMP_W'(pos_reg));
    assign ind_room  = (ind_cnt_reg < 2'(IND_MAX));
    assign ind_due   = ind_room && (ind1_hit || ind2_hit);
    assign limit_hit = (res_cnt_reg == RESULT_CNT_W'(RESULT_LIMIT));
    assign can_send  = !out_valid_reg || cipher_out.ready;
    assign can_put   = !held_valid_reg || can_send;
    assign finish_go = !held_valid_reg || can_send;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = B_ADDR;
                end
            end
            B_ADDR:
            begin
                if (limit_hit)
                begin
                    state_next = B_FINISH;
                end
                else if (in_range)
                begin
                    state_next = B_DATA;
                end
                else if (last_cell)
                begin
                    state_next = B_FINISH;
                end
            end
            B_DATA:
            begin
                if (!is_marker)
                begin
                    state_next = B_EMIT;
                end
                else if (last_cell)
                begin
                    state_next = B_FINISH;
                end
                else
                begin
                    state_next = B_ADDR;
                end
            end
            B_EMIT:
            begin
                if (limit_hit)
                begin
                    state_next = B_FINISH;
                end
                else if (can_put && !ind_due)
                begin
                    state_next = last_cell ? B_FINISH : B_ADDR;
                end
            end
            B_FINISH:
            begin
                if (finish_go)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Output decode
    always_comb
    begin
        cmd_pop   = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = {cur_reg.bank, idx_reg[ADDR_W-1:0]};
        adv       = 1'b0;
        put       = 1'b0;
        put_ind   = 1'b0;
        put_char  = ram_rdata;
        finish    = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                cmd_pop = cmd_valid;
            end
            B_ADDR:
            begin
                if (!limit_hit)
                begin
                    ram_re = in_range;
                    adv    = !in_range && !last_cell;
                end
            end
            B_DATA:
            begin
                adv = is_marker && !last_cell;
            end
            B_EMIT:
            begin
                if (!limit_hit && can_put)
                begin
                    put = 1'b1;
                    if (ind_due)
                    begin
                        put_ind  = 1'b1;
                        put_char = ind1_hit ? cfg.ind1_char : cfg.ind2_char;
                    end
                    else
                    begin
                        adv = !last_cell;
                    end
                end
            end
            B_FINISH:
            begin
                finish = finish_go;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
        bank_free.valid = finish;
        bank_free.bank  = cur_reg.bank;
        cipher_out.valid       = out_valid_reg;
        cipher_out.cipher_char = out_char_reg;
        cipher_out.run_end     = out_end_reg;
    end

    // Datapath
    always_comb
    begin
        cur_next        = cur_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        ind_cnt_next    = ind_cnt_reg;
        res_cnt_next    = res_cnt_reg;
        held_valid_next = held_valid_reg;
        held_char_next  = held_char_reg;
        out_valid_next  = out_valid_reg && !cipher_out.ready;
        out_char_next   = out_char_reg;
        out_end_next    = out_end_reg;

        // Start a readout pass
        if (cmd_pop)
        begin
            cur_next     = cmd;
            row_next     = '0;
            col_next     = '0;
            idx_next     = '0;
            res_cnt_next = '0;
        end

        // Step down the column, then to the top of the next column
        if (adv)
        begin
            if (last_row)
            begin
                row_next = '0;
                col_next = col_reg + COL_W'(1);
                idx_next = CNT_W'(col_reg) + CNT_W'(1);
            end
            else
            begin
                row_next = row_reg + ROW_W'(1);
                idx_next = idx_reg + CNT_W'(GRID_COLS);
            end
        end

        // Clear indicator count on each new character
        if (state_reg == B_DATA)
        begin
            ind_cnt_next = '0;
        end

        // Produce a word: forward the held one, hold the new one
        if (put)
        begin
            if (held_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_char_next  = held_char_reg;
                out_end_next   = 1'b0;
            end
            held_valid_next = 1'b1;
            held_char_next  = put_char;
            res_cnt_next    = res_cnt_reg + RESULT_CNT_W'(1);
            pos_next        = (pos_reg == POS_W'(MAX_OUTPUT - 1)) ? '0 : pos_reg + POS_W'(1);
            if (put_ind)
            begin
                ind_cnt_next = ind_cnt_reg + 2'd1;
            end
        end

        // Close the pass: last held word carries the end mark
        if (finish)
        begin
            if (held_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_char_next  = held_char_reg;
                out_end_next   = 1'b1;
            end
            held_valid_next = 1'b0;
            if (cur_reg.is_final)
            begin
                pos_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            pos_reg        <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            res_cnt_reg    <= '0;
            ind_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
            res_cnt_reg    <= res_cnt_next;
            ind_cnt_reg    <= ind_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        idx_reg       <= idx_next;
        held_char_reg <= held_char_next;
        out_char_reg  <= out_char_next;
        out_end_reg   <= out_end_next;
    end

endmodule

[rtl/grille_transposition_encrypt.sv]
// Grille transposition encryptor. An item steps the front fill loop over each closed cell
// before its open cell; an item that closes a group also queues a readout command.
// A readout starts, passes over cells outside the fill count, reads each filled cell,
// sends its words and finishes; output stalls can hold it.
// Two grid banks let the front fill one group while the back reads out the other.
// Reset: config takes its defaults, fill and output position go to zero, cells not cleared.
module grille_transposition_encrypt import gte_pkg::*; #(
    parameter int GRID_ROWS  = DEF_GRID_ROWS,
    parameter int GRID_COLS  = DEF_GRID_COLS,
    parameter int MAX_OUTPUT = DEF_MAX_OUTPUT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    gte_in_if.sink                plain_in,
    gte_out_if.source             cipher_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int RAM_DEPTH  = 2 ** (ADDR_W + 1);

    logic [MASK_BITS-1:0] mask_reg, mask_next;
    cipher_cfg_t          cfg_reg, cfg_next;

    logic                 ram_we;
    logic [ADDR_W:0]      ram_waddr;
    logic [CHAR_W-1:0]    ram_wdata;
    logic                 ram_re;
    logic [ADDR_W:0]      ram_raddr;
    logic [CHAR_W-1:0]    ram_rdata;
    logic                 front_cmd_valid;
    readout_cmd_t         front_cmd;
    logic                 front_cmd_ready;
    logic                 back_cmd_valid;
    readout_cmd_t         back_cmd;
    logic                 back_cmd_pop;
    bank_release_t        bank_free;

    // Register writes
    always_comb
    begin
        mask_next = mask_reg;
        cfg_next  = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_OPEN_MASK:    mask_next            = cfg_data[MASK_BITS-1:0];
                CFG_EMPTY_MARKER: cfg_next.empty_marker = cfg_data[CHAR_W-1:0];
                CFG_IND1_CHAR:    cfg_next.ind1_char    = cfg_data[CHAR_W-1:0];
                CFG_IND1_INDEX:   cfg_next.ind1_index   = cfg_data[INDEX_W-1:0];
                CFG_IND2_CHAR:    cfg_next.ind2_char    = cfg_data[CHAR_W-1:0];
                CFG_IND2_INDEX:   cfg_next.ind2_index   = cfg_data[INDEX_W-1:0];
                default:          mask_next            = mask_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg             <= MASK_RESET;
            cfg_reg.empty_marker <= MARKER_RESET;
            cfg_reg.ind1_char    <= '0;
            cfg_reg.ind1_index   <= '0;
            cfg_reg.ind2_char    <= '0;
            cfg_reg.ind2_index   <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
            cfg_reg  <= cfg_next;
        end
    end

    gte_front #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .plain_in       (plain_in),
        .open_cell_mask (mask_reg),
        .empty_marker   (cfg_reg.empty_marker),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .cmd_valid      (front_cmd_valid),
        .cmd            (front_cmd),
        .cmd_ready      (front_cmd_ready),
        .bank_free      (bank_free)
    );

    gte_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (RAM_DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gte_cmd_fifo u_cmd_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_cmd_valid),
        .push_cmd   (front_cmd),
        .push_ready (front_cmd_ready),
        .pop_valid  (back_cmd_valid),
        .pop_cmd    (back_cmd),
        .pop        (back_cmd_pop)
    );

    gte_back #(
        .GRID_ROWS  (GRID_ROWS),
        .GRID_COLS  (GRID_COLS),
        .MAX_OUTPUT (MAX_OUTPUT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (back_cmd_valid),
        .cmd        (back_cmd),
        .cmd_pop    (back_cmd_pop),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .cfg        (cfg_reg),
        .cipher_out (cipher_out),
        .bank_free  (bank_free)
    );

endmodule

[tb/gte_encrypt_checker.sv]
// Checker for the grille transposition encryptor: watches the plaintext,
// ciphertext and register-write ports, predicts every ciphertext word and compares.
// Depends on gte_pkg and the gte_in_if / gte_out_if interfaces.
module gte_encrypt_checker import gte_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    gte_in_if                     plain_in,
    gte_out_if                    cipher_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    error_count,
    output int                    words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS      = DEF_GRID_ROWS * DEF_GRID_COLS;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] cipher_char;
        logic              run_end;
    } cipher_word_t;

    cipher_word_t cipher_q[$];

    // Predictor state
    logic [CHAR_W-1:0]  grid_cell [CELLS];
    int                 fill_pos;
    logic [INDEX_W-1:0] out_pos;
    int                 step_words;

    // Register copy
    logic [MASK_BITS-1:0] open_mask;
    logic [CHAR_W-1:0]    marker;
    logic [CHAR_W-1:0]    ind1_char;
    logic [INDEX_W-1:0]   ind1_idx;
    logic [CHAR_W-1:0]    ind2_char;
    logic [INDEX_W-1:0]   ind2_idx;

    int mismatches = 0;
    assign error_count = mismatches;

    function automatic bit cell_open(int i);
        if (i >= MASK_BITS)
            return 1'b0;
        return open_mask[i];
    endfunction

    // Queue one word; out_pos wraps at 4096 through its 12-bit width
    function automatic void queue_word(logic [CHAR_W-1:0] ch);
        if (step_words >= RESULT_LIMIT)
            return;
        cipher_q.push_back('{cipher_char: ch, run_end: 1'b0});
        step_words++;
        out_pos = out_pos + 1'b1;
    endfunction

    // Insert due indicators, then the ciphertext character itself
    function automatic void send_cipher(logic [CHAR_W-1:0] ch);
        for (int k = 0; k < 2; k++) begin
            if (ind1_char != '0 && ind1_idx == out_pos)
                queue_word(ind1_char);
            else if (ind2_char != '0 && ind2_idx == out_pos)
                queue_word(ind2_char);
            else
                break;
        end
        queue_word(ch);
    endfunction

    // Read the group column by column, skipping marker cells
    function automatic void flush_group();
        int i;
        for (int col = 0; col < DEF_GRID_COLS; col++) begin
            for (int row = 0; row < DEF_GRID_ROWS; row++) begin
                i = row * DEF_GRID_COLS + col;
                if (i < fill_pos && grid_cell[i] != marker)
                    send_cipher(grid_cell[i]);
            end
        end
        fill_pos = 0;
    endfunction

    function automatic void encrypt_char(logic [CHAR_W-1:0] pc, logic fin);
        bit closes;
        step_words = 0;
        // Pad closed cells with the marker up to the next open cell
        while (fill_pos < CELLS && !cell_open(fill_pos)) begin
            grid_cell[fill_pos] = marker;
            fill_pos++;
        end
        if (fill_pos < CELLS) begin
            grid_cell[fill_pos] = pc;
            fill_pos++;
            closes = 1'b1;
            for (int j = fill_pos; j < CELLS; j++) begin
                if (cell_open(j)) begin
                    closes = 1'b0;
                    break;
                end
            end
        end
        else begin
            // No open cell left: drop the character and close the group
            closes = 1'b1;
        end
        if (closes || fin)
            flush_group();
        if (fin) begin
            fill_pos = 0;
            out_pos  = '0;
        end
        if (step_words > 0)
            cipher_q[cipher_q.size()-1].run_end = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        cipher_word_t want;
        if (!rst_n) begin
            open_mask = MASK_RESET;
            marker    = MARKER_RESET;
            ind1_char = '0;
            ind1_idx  = '0;
            ind2_char = '0;
            ind2_idx  = '0;
            fill_pos  = 0;
            out_pos   = '0;
            cipher_q.delete();
        end
        else begin
            // Track register writes
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    CFG_OPEN_MASK:    open_mask = cfg_data[MASK_BITS-1:0];
                    CFG_EMPTY_MARKER: marker    = cfg_data[CHAR_W-1:0];
                    CFG_IND1_CHAR:    ind1_char = cfg_data[CHAR_W-1:0];
                    CFG_IND1_INDEX:   ind1_idx  = cfg_data[INDEX_W-1:0];
                    CFG_IND2_CHAR:    ind2_char = cfg_data[CHAR_W-1:0];
                    CFG_IND2_INDEX:   ind2_idx  = cfg_data[INDEX_W-1:0];
                    default: ;
                endcase
            end
            // Compare an accepted ciphertext word with the oldest prediction
            if (cipher_out.valid && cipher_out.ready) begin
                if (cipher_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: unexpected word char=%02h run_end=%0b", $time,
                                 cipher_out.cipher_char, cipher_out.run_end);
                end
                else begin
                    want = cipher_q.pop_front();
                    if (cipher_out.cipher_char !== want.cipher_char ||
                        cipher_out.run_end !== want.run_end) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: word mismatch char exp=%02h got=%02h, run_end exp=%0b got=%0b",
                                     $time, want.cipher_char, cipher_out.cipher_char,
                                     want.run_end, cipher_out.run_end);
                    end
                end
            end
            // Predict the words of an accepted plaintext word
            if (plain_in.valid && plain_in.ready)
                encrypt_char(plain_in.plain_char, plain_in.is_final);
        end
        words_pending = cipher_q.size();
    end

endmodule

[tb/grille_transposition_encrypt_test.sv]
// Testbench top for the grille transposition encryptor: clock, reset, register
// writes, plaintext stimulus and ciphertext back-pressure, and the verdict.
// Depends on gte_pkg, the channel interfaces, the RTL and gte_encrypt_checker.
module grille_transposition_encrypt_test;
    import gte_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 120;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 27;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int error_count;
    int words_pending;

    gte_in_if  plain_in ();
    gte_out_if cipher_out ();

    grille_transposition_encrypt i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .plain_in   (plain_in),
        .cipher_out (cipher_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    gte_encrypt_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .plain_in      (plain_in),
        .cipher_out    (cipher_out),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .words_pending (words_pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hold off ciphertext words at random
    always @(negedge clk)
    begin
        cipher_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Give up on a hung run
    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_all(logic [MASK_BITS-1:0] mask, logic [CHAR_W-1:0] mark,
                             logic [CHAR_W-1:0] c1, logic [INDEX_W-1:0] p1,
                             logic [CHAR_W-1:0] c2, logic [INDEX_W-1:0] p2);
        write_reg(CFG_OPEN_MASK, CFG_DATA_W'(mask));
        write_reg(CFG_EMPTY_MARKER, CFG_DATA_W'(mark));
        write_reg(CFG_IND1_CHAR, CFG_DATA_W'(c1));
        write_reg(CFG_IND1_INDEX, CFG_DATA_W'(p1));
        write_reg(CFG_IND2_CHAR, CFG_DATA_W'(c2));
        write_reg(CFG_IND2_INDEX, CFG_DATA_W'(p2));
    endtask

    // Offer one plaintext word, idling first at random; return at a falling edge
    task automatic send_char(logic [CHAR_W-1:0] ch, logic fin);
        while ($urandom_range(99) < send_gap_pct) begin
            plain_in.valid <= 1'b0;
            @(negedge clk);
        end
        plain_in.valid      <= 1'b1;
        plain_in.plain_char <= ch;
        plain_in.is_final   <= fin;
        do
            @(posedge clk);
        while (!plain_in.ready);
        @(negedge clk);
    endtask

    // Drop valid, wait for every predicted word, then let the block settle
    task automatic wait_quiet();
        plain_in.valid <= 1'b0;
        while (words_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Random settings, then messages with random content until the budget is spent
    task automatic random_phase(int budget);
        logic [MASK_BITS-1:0] mask;
        logic [CHAR_W-1:0]    mark;
        logic [CHAR_W-1:0]    c1;
        logic [CHAR_W-1:0]    c2;
        logic [INDEX_W-1:0]   p1;
        logic [INDEX_W-1:0]   p2;
        logic [CHAR_W-1:0]    ch;
        int                   len;
        bit                   closed;
        case ($urandom_range(4))
            0: mask = '1;
            1: mask = MASK_BITS'(1) << $urandom_range(MASK_BITS-1);
            2: mask = MASK_BITS'($urandom);
            3: mask = MASK_BITS'($urandom & $urandom);
            default: mask = MASK_BITS'($urandom | $urandom);
        endcase
        mark = CHAR_W'($urandom_range(255));
        c1 = ($urandom_range(3) == 0) ? '0 : CHAR_W'($urandom_range(1, 255));
        c2 = ($urandom_range(3) == 0) ? '0 : CHAR_W'($urandom_range(1, 255));
        p1 = ($urandom_range(3) == 0) ? INDEX_W'($urandom_range(4095))
                                      : INDEX_W'($urandom_range(40));
        p2 = ($urandom_range(3) == 0) ? INDEX_W'($urandom_range(4095))
                                      : INDEX_W'($urandom_range(40));
        write_all(mask, mark, c1, p1, c2, p2);
        while (budget > 0) begin
            len = $urandom_range(1, 36);
            // Leave some messages open so they run into the next one
            closed = ($urandom_range(99) >= 15);
            for (int i = 0; i < len && budget > 0; i++) begin
                ch = ($urandom_range(7) == 0) ? mark : CHAR_W'($urandom_range(255));
                send_char(ch, closed && (i == len - 1));
                budget--;
            end
        end
        wait_quiet();
    endtask

    initial
    begin
        int waited;
        plain_in.valid      = 1'b0;
        plain_in.plain_char = '0;
        plain_in.is_final   = 1'b0;
        cipher_out.ready    = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_gap_pct   = 25;
        recv_stall_pct = 77;

        // Default settings: byte extremes and a byte equal to the marker, then flush
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(MARKER_RESET, 1'b0);
        send_char(8'h55, 1'b0);
        send_char(8'hAA, 1'b1);
        wait_quiet();

        // All cells open, both indicators at one position
        write_all('1, 8'hFF, 8'h49, 12'd2, 8'hFF, 12'd2);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(8'h7F, 1'b0);
        send_char(8'h41, 1'b1);
        wait_quiet();

        // No open cell: characters are dropped
        write_all('0, 8'h00, 8'h00, 12'd4095, 8'h4B, 12'd1);
        send_char(8'h12, 1'b0);
        send_char(8'h34, 1'b0);
        wait_quiet();

        // Indicators at adjacent positions, then a mask cut mid group
        write_all(30'h3, 8'h00, 8'h4D, 12'd0, 8'h4E, 12'd1);
        send_char(8'h61, 1'b0);
        send_char(8'h62, 1'b0);
        send_char(8'h63, 1'b0);
        wait_quiet();
        write_reg(CFG_OPEN_MASK, CFG_DATA_W'(30'h1));
        send_char(8'h64, 1'b0);
        wait_quiet();

        // Indicator due right after the last word of a step waits for the next one
        write_reg(CFG_OPEN_MASK, CFG_DATA_W'(30'h3));
        write_reg(CFG_IND1_CHAR, CFG_DATA_W'(8'h45));
        write_reg(CFG_IND1_INDEX, CFG_DATA_W'(12'd7));
        write_reg(CFG_IND2_CHAR, CFG_DATA_W'(8'h00));
        send_char(8'h65, 1'b0);
        send_char(8'h66, 1'b0);
        send_char(8'h67, 1'b0);
        send_char(8'h68, 1'b1);
        wait_quiet();

        // Random phases under three back-pressure profiles
        for (int p = 0; p < 3; p++)
            random_phase(PHASE_ITEMS);
        send_gap_pct   = 77;
        recv_stall_pct = 25;
        for (int p = 0; p < 3; p++)
            random_phase(PHASE_ITEMS);
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        for (int p = 0; p < 3; p++)
            random_phase(PHASE_ITEMS);
        plain_in.valid <= 1'b0;

        // Drain, then give the verdict
        waited = 0;
        while (words_pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_count == 0 && words_pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[grille_transposition_encrypt.f]
rtl/gte_pkg.sv
rtl/gte_in_if.sv
rtl/gte_out_if.sv
rtl/gte_ram.sv
rtl/gte_front.sv
rtl/gte_cmd_fifo.sv
rtl/gte_back.sv
rtl/grille_transposition_encrypt.sv
tb/gte_encrypt_checker.sv
tb/grille_transposition_encrypt_test.sv
